// ----- hw/rtl/wsa_pkg.sv -----
// wsa_pkg: command codes, field widths and control structs for the wakeup source accounting unit
// no dependencies; used by wsa_table, wsa_alu and wakeup_source_accounting_unit
`default_nettype none
package wsa_pkg;

  localparam int CMD_W = 3;
  localparam int VEC_W = 8;
  localparam int OUT_W = 32;
  localparam int SRC_W = 9;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ARM    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ATTR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MON    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNATTR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_REPORT = 3'd6;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             clr;
    logic [VEC_W-1:0] raddr;
    logic [VEC_W-1:0] waddr;
  } tbl_ctl_t;

  typedef struct packed {
    logic gt;
    logic eq;
    logic nz;
  } alu_flags_t;

endpackage
`default_nettype wire

// ----- hw/rtl/wakeup_source_accounting_unit.sv -----
// wakeup_source_accounting_unit: sequencer, counters and result register of the unit
// depends on wsa_pkg, wsa_table and wsa_alu
// clear and idle closes go from idle straight to the done state; arm, close, attribute and read
// pass through a bump or read-modify-write state; report walks the table one entry a cycle
// through the read port, then runs the balance steps S_BAL1 to S_BAL4; one word in flight,
// so a new word is taken only in idle, and it is taken while the result waits in its register
// synchronous reset clears the event counters, the armed flag and every table valid bit at once
`default_nettype none
module wakeup_source_accounting_unit #(
  parameter int VECTORS     = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cmd_valid,
  output logic                               cmd_stall,
  input  wire logic [wsa_pkg::CMD_W-1:0]     cmd,
  input  wire logic [wsa_pkg::VEC_W-1:0]     vector,
  output logic                               result_valid,
  input  wire                                result_stall,
  output logic                               armed,
  output logic      [wsa_pkg::OUT_W-1:0]     vector_count,
  output logic      [wsa_pkg::OUT_W-1:0]     sleep_total,
  output logic      [wsa_pkg::OUT_W-1:0]     monitor_total,
  output logic      [wsa_pkg::OUT_W-1:0]     unattributed_total,
  output logic      [wsa_pkg::OUT_W-1:0]     double_arm_total,
  output logic      [wsa_pkg::OUT_W-1:0]     attributed_total,
  output logic      [wsa_pkg::SRC_W-1:0]     source_total,
  output logic      [wsa_pkg::SRC_W-1:0]     busiest,
  output logic      [wsa_pkg::OUT_W-1:0]     busiest_total,
  output logic                               balanced
);

  localparam int IDX_W = (VECTORS > 1) ? $clog2(VECTORS) : 1;
  localparam int EXT_W = (COUNT_WIDTH > wsa_pkg::OUT_W) ? COUNT_WIDTH : wsa_pkg::OUT_W;
  localparam logic [IDX_W-1:0]          LAST_IDX = IDX_W'(VECTORS - 1);
  localparam logic [wsa_pkg::SRC_W-1:0] NO_SRC   = wsa_pkg::SRC_W'(VECTORS);

  typedef enum logic [3:0] {
    S_IDLE, S_BUMP, S_RMW, S_WALK, S_BAL1, S_BAL2, S_BAL3, S_BAL4, S_DONE
  } state_t;

  function automatic logic [wsa_pkg::OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    return w[wsa_pkg::OUT_W-1:0];
  endfunction

  state_t                        state;
  logic [wsa_pkg::CMD_W-1:0]     cmd_r;
  logic [wsa_pkg::VEC_W-1:0]     vec_r;
  logic                          armed_flag;
  logic [COUNT_WIDTH-1:0]        sleeps;
  logic [COUNT_WIDTH-1:0]        monitor_wakes;
  logic [COUNT_WIDTH-1:0]        unknown_wakes;
  logic [COUNT_WIDTH-1:0]        rearms;
  logic [COUNT_WIDTH-1:0]        vcount;
  logic [COUNT_WIDTH-1:0]        acc;
  logic [COUNT_WIDTH-1:0]        chk;
  logic [COUNT_WIDTH-1:0]        best;
  logic [wsa_pkg::SRC_W-1:0]     src_cnt;
  logic [wsa_pkg::SRC_W-1:0]     busiest_idx;
  logic                          bal;
  logic [IDX_W-1:0]              walk_idx;
  logic                          issue_done;
  logic                          pend;
  logic [IDX_W-1:0]              pend_idx;

  logic                          accept;
  logic                          in_table;
  logic                          do_write;
  wsa_pkg::tbl_ctl_t             tctl;
  logic [COUNT_WIDTH-1:0]        rdata;
  logic [COUNT_WIDTH-1:0]        add_a;
  logic [COUNT_WIDTH-1:0]        add_b;
  logic [COUNT_WIDTH-1:0]        cmp_a;
  logic [COUNT_WIDTH-1:0]        cmp_b;
  logic [COUNT_WIDTH-1:0]        sum;
  wsa_pkg::alu_flags_t           flags;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign in_table  = {1'b0, vector} < NO_SRC;
  assign do_write  = (state == S_RMW) && (cmd_r == wsa_pkg::CMD_ATTR) && armed_flag;

  always_comb begin
    tctl       = '0;
    tctl.waddr = vec_r;
    tctl.raddr = vector;
    if (accept) begin
      tctl.clr   = (cmd == wsa_pkg::CMD_CLEAR);
      tctl.rd_en = in_table && ((cmd == wsa_pkg::CMD_ATTR) || (cmd == wsa_pkg::CMD_READ));
    end
    if (state == S_WALK) begin
      tctl.rd_en = !issue_done;
      tctl.raddr = wsa_pkg::VEC_W'(walk_idx);
    end
    tctl.wr_en = do_write;
  end

  // operand selection for the shared unit
  always_comb begin
    add_a = '0;
    add_b = '0;
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      S_BUMP: begin
        add_b = COUNT_WIDTH'(1);
        case (cmd_r)
          wsa_pkg::CMD_ARM: add_a = armed_flag ? rearms : sleeps;
          wsa_pkg::CMD_MON: add_a = monitor_wakes;
          default:          add_a = unknown_wakes;
        endcase
      end
      S_RMW: begin
        add_a = rdata;
        add_b = COUNT_WIDTH'(1);
      end
      S_WALK: begin
        add_a = acc;
        add_b = rdata;
        cmp_a = rdata;
        cmp_b = best;
      end
      S_BAL1: begin
        add_a = acc;
        add_b = monitor_wakes;
      end
      S_BAL2: begin
        add_a = chk;
        add_b = unknown_wakes;
      end
      S_BAL3: begin
        add_a = chk;
        add_b = COUNT_WIDTH'(armed_flag);
      end
      S_BAL4: begin
        cmp_a = chk;
        cmp_b = sleeps;
      end
      default: begin
      end
    endcase
  end

  wsa_table #(
    .VECTORS     (VECTORS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tctl),
    .wdata (sum),
    .rdata (rdata)
  );

  wsa_alu #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_alu (
    .add_a (add_a),
    .add_b (add_b),
    .cmp_a (cmp_a),
    .cmp_b (cmp_b),
    .sum   (sum),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      armed_flag    <= 1'b0;
      sleeps        <= '0;
      monitor_wakes <= '0;
      unknown_wakes <= '0;
      rearms        <= '0;
      pend          <= 1'b0;
      issue_done    <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r       <= cmd;
            vec_r       <= vector;
            vcount      <= '0;
            acc         <= '0;
            best        <= '0;
            src_cnt     <= '0;
            busiest_idx <= (cmd == wsa_pkg::CMD_REPORT) ? NO_SRC : '0;
            bal         <= 1'b0;
            case (cmd)
              wsa_pkg::CMD_CLEAR: begin
                armed_flag    <= 1'b0;
                sleeps        <= '0;
                monitor_wakes <= '0;
                unknown_wakes <= '0;
                rearms        <= '0;
                state         <= S_DONE;
              end
              wsa_pkg::CMD_ARM: state <= S_BUMP;
              wsa_pkg::CMD_ATTR: begin
                if (in_table) begin
                  state <= S_RMW;
                end else if (armed_flag) begin
                  state <= S_BUMP;
                end else begin
                  state <= S_DONE;
                end
              end
              wsa_pkg::CMD_MON, wsa_pkg::CMD_UNATTR: begin
                state <= armed_flag ? S_BUMP : S_DONE;
              end
              wsa_pkg::CMD_READ: state <= in_table ? S_RMW : S_DONE;
              wsa_pkg::CMD_REPORT: begin
                walk_idx    <= '0;
                issue_done  <= 1'b0;
                pend        <= 1'b0;
                state       <= S_WALK;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_BUMP: begin
          case (cmd_r)
            wsa_pkg::CMD_ARM: begin
              if (armed_flag) begin
                rearms <= sum;
              end else begin
                sleeps <= sum;
              end
              armed_flag <= 1'b1;
            end
            wsa_pkg::CMD_MON: begin
              monitor_wakes <= sum;
              armed_flag    <= 1'b0;
            end
            default: begin
              unknown_wakes <= sum;
              armed_flag    <= 1'b0;
            end
          endcase
          state <= S_DONE;
        end
        S_RMW: begin
          if (do_write) begin
            vcount     <= sum;
            armed_flag <= 1'b0;
          end else begin
            vcount <= rdata;
          end
          state <= S_DONE;
        end
        S_WALK: begin
          if (!issue_done) begin
            walk_idx   <= walk_idx + IDX_W'(1);
            issue_done <= (walk_idx == LAST_IDX);
          end
          pend     <= !issue_done;
          pend_idx <= walk_idx;
          if (pend) begin
            acc <= sum;
            if (flags.nz) begin
              src_cnt <= src_cnt + wsa_pkg::SRC_W'(1);
            end
            if (flags.gt) begin
              best        <= rdata;
              busiest_idx <= wsa_pkg::SRC_W'(pend_idx);
            end
            if (pend_idx == LAST_IDX) begin
              state <= S_BAL1;
            end
          end
        end
        S_BAL1: begin
          chk   <= sum;
          state <= S_BAL2;
        end
        S_BAL2: begin
          chk   <= sum;
          state <= S_BAL3;
        end
        S_BAL3: begin
          chk   <= sum;
          state <= S_BAL4;
        end
        S_BAL4: begin
          bal   <= flags.eq;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!result_valid || !result_stall)) begin
      armed              <= armed_flag;
      vector_count       <= to_out(vcount);
      sleep_total        <= to_out(sleeps);
      monitor_total      <= to_out(monitor_wakes);
      unattributed_total <= to_out(unknown_wakes);
      double_arm_total   <= to_out(rearms);
      attributed_total   <= to_out(acc);
      source_total       <= src_cnt;
      busiest            <= busiest_idx;
      busiest_total      <= to_out(best);
      balanced           <= bal;
    end
  end

  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> cmd_stall)
    else $error("word accepted without the sequencer leaving idle");

  a_write_only_armed: assert property (@(posedge clk) disable iff (rst)
    tctl.wr_en |-> (armed_flag && (state == S_RMW)))
    else $error("table written outside an armed attribute");

  a_sources_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (src_cnt <= NO_SRC))
    else $error("source count beyond table depth");

  a_no_source_no_best: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (source_total == '0)) |-> (busiest_total == '0))
    else $error("busiest count set with no sources");

  a_walk_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state != S_WALK) |-> !(tctl.rd_en && tctl.wr_en))
    else $error("table read and write in the same cycle");

endmodule
`default_nettype wire

// ----- hw/rtl/wsa_table.sv -----
// wsa_table: vector count memory with registered read and per-entry valid bits
// depends on wsa_pkg for tbl_ctl_t
`default_nettype none
module wsa_table #(
  parameter int VECTORS     = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire wsa_pkg::tbl_ctl_t       ctl,
  input  wire logic [COUNT_WIDTH-1:0]  wdata,
  output logic      [COUNT_WIDTH-1:0]  rdata
);

  localparam int IDX_W = (VECTORS > 1) ? $clog2(VECTORS) : 1;

  logic [COUNT_WIDTH-1:0] mem [VECTORS];
  logic [VECTORS-1:0]     valid;
  logic [COUNT_WIDTH-1:0] data_q;
  logic                   valid_q;
  logic [IDX_W-1:0]       raddr;
  logic [IDX_W-1:0]       waddr;

  assign raddr = ctl.raddr[IDX_W-1:0];
  assign waddr = ctl.waddr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      data_q  <= mem[raddr];
      valid_q <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[waddr] <= 1'b1;
    end
  end

  // unwritten entries read as zero
  assign rdata = valid_q ? data_q : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/wsa_alu.sv -----
// wsa_alu: shared adder and magnitude compare used by the bump, read-modify-write, walk and balance steps
// depends on wsa_pkg for alu_flags_t
`default_nettype none
module wsa_alu #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic [COUNT_WIDTH-1:0] add_a,
  input  wire logic [COUNT_WIDTH-1:0] add_b,
  input  wire logic [COUNT_WIDTH-1:0] cmp_a,
  input  wire logic [COUNT_WIDTH-1:0] cmp_b,
  output logic      [COUNT_WIDTH-1:0] sum,
  output wsa_pkg::alu_flags_t         flags
);

  assign sum      = add_a + add_b;
  assign flags.gt = cmp_a > cmp_b;
  assign flags.eq = cmp_a == cmp_b;
  assign flags.nz = cmp_a != '0;

endmodule
`default_nettype wire
